/* sv/irqt_pkg.sv */
package irqt_pkg;

  // fixed widths of the register file and the result dimensions
  localparam int DIM_W     = 7;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_QUARTER_TURNS = 2'd2,
    REG_TURN_LEFT    = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  // clockwise turn after folding left turns
  typedef enum logic [1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turn_e;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] oh;
    turn_e            turns;
  } cfg_t;

  typedef struct packed {
    logic             row_end;
    logic             frame_end;
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] oh;
  } out_info_t;

endpackage

/* sv/irqt_regs.sv */
module irqt_regs #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [irqt_pkg::PADDR_W-1:0]       paddr,
  input  logic [irqt_pkg::PDATA_W-1:0]       pwdata,
  output logic [irqt_pkg::PDATA_W-1:0]       prdata,
  output irqt_pkg::cfg_t                     cfg_o
);

  localparam int EFF_W = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
  localparam int EFF_H = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;

  logic [irqt_pkg::DIM_W-1:0] width_q, height_q;
  logic [1:0]                 quarter_q;
  logic                       left_q;
  logic                       wr_en;
  irqt_pkg::reg_idx_e         idx;
  logic [irqt_pkg::DIM_W-1:0] w, h;
  irqt_pkg::turn_e            turns;

  assign wr_en = psel & penable & pwrite;
  assign idx   = irqt_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= irqt_pkg::DIM_RESET;
      height_q  <= irqt_pkg::DIM_RESET;
      quarter_q <= '0;
      left_q    <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        irqt_pkg::REG_IMAGE_WIDTH:   width_q   <= pwdata[irqt_pkg::DIM_W-1:0];
        irqt_pkg::REG_IMAGE_HEIGHT:  height_q  <= pwdata[irqt_pkg::DIM_W-1:0];
        irqt_pkg::REG_QUARTER_TURNS: quarter_q <= pwdata[1:0];
        irqt_pkg::REG_TURN_LEFT:     left_q    <= pwdata[0];
        default:                     left_q    <= left_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      irqt_pkg::REG_IMAGE_WIDTH:   prdata = irqt_pkg::PDATA_W'(width_q);
      irqt_pkg::REG_IMAGE_HEIGHT:  prdata = irqt_pkg::PDATA_W'(height_q);
      irqt_pkg::REG_QUARTER_TURNS: prdata = irqt_pkg::PDATA_W'(quarter_q);
      irqt_pkg::REG_TURN_LEFT:     prdata = irqt_pkg::PDATA_W'(left_q);
      default:                     prdata = '0;
    endcase
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (width_q == '0) begin
      w = irqt_pkg::DIM_W'(1);
    end else if (width_q > irqt_pkg::DIM_W'(EFF_W)) begin
      w = irqt_pkg::DIM_W'(EFF_W);
    end else begin
      w = width_q;
    end
    if (height_q == '0) begin
      h = irqt_pkg::DIM_W'(1);
    end else if (height_q > irqt_pkg::DIM_W'(EFF_H)) begin
      h = irqt_pkg::DIM_W'(EFF_H);
    end else begin
      h = height_q;
    end
    turns = left_q ? irqt_pkg::turn_e'(2'(2'd0 - quarter_q)) : irqt_pkg::turn_e'(quarter_q);
  end

  assign cfg_o.w     = w;
  assign cfg_o.h     = h;
  assign cfg_o.turns = turns;
  assign cfg_o.ow    = turns[0] ? h : w;
  assign cfg_o.oh    = turns[0] ? w : h;

endmodule

/* sv/irqt_seq.sv */
module irqt_seq #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  irqt_pkg::cfg_t                         cfg_i,
  input  logic                                   acc_i,
  input  irqt_pkg::op_e                          op_i,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] mem_addr_o,
  output logic                                   mem_we_o,
  output logic                                   mem_re_o,
  output irqt_pkg::out_info_t                    info_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int EFF_W = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
  localparam int EFF_H = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
  localparam int MAXD  = (EFF_W > EFF_H) ? EFF_W : EFF_H;
  localparam int PW    = $clog2(MAXD);
  localparam int DW    = irqt_pkg::DIM_W;
  localparam int MW    = 2 * DW;
  localparam int CW    = (LW > MW) ? LW : MW;

  logic [LW-1:0] load_cnt_q, load_cnt_d;
  logic [PW-1:0] row_q, row_d, col_q, col_d;
  logic [DW-1:0] row_e, col_e, r, c;
  logic [MW-1:0] total, addr_full;
  logic          load_ok, rend, fend;

  // position wraps to zero if it lies outside the current output frame
  always_comb begin
    col_e = (DW'(col_q) >= cfg_i.ow) ? '0 : DW'(col_q);
    row_e = (DW'(row_q) >= cfg_i.oh) ? '0 : DW'(row_q);
    unique case (cfg_i.turns)
      irqt_pkg::TURN_0: begin
        r = row_e;
        c = col_e;
      end
      irqt_pkg::TURN_90: begin
        r = cfg_i.h - DW'(1) - col_e;
        c = row_e;
      end
      irqt_pkg::TURN_180: begin
        r = cfg_i.h - DW'(1) - row_e;
        c = cfg_i.w - DW'(1) - col_e;
      end
      irqt_pkg::TURN_270: begin
        r = col_e;
        c = cfg_i.w - DW'(1) - row_e;
      end
      default: begin
        r = row_e;
        c = col_e;
      end
    endcase
  end

  assign addr_full = MW'(r) * MW'(cfg_i.w) + MW'(c);
  assign total     = MW'(cfg_i.w) * MW'(cfg_i.h);
  assign load_ok   = CW'(load_cnt_q) < CW'(total);
  assign rend      = (col_e == cfg_i.ow - DW'(1));
  assign fend      = rend && (row_e == cfg_i.oh - DW'(1));

  always_comb begin
    load_cnt_d = load_cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    mem_we_o   = 1'b0;
    mem_re_o   = 1'b0;
    mem_addr_o = AW'(addr_full);
    if (acc_i) begin
      if (op_i == irqt_pkg::OP_LOAD) begin
        if (load_ok) begin
          mem_we_o   = 1'b1;
          mem_addr_o = AW'(load_cnt_q);
          load_cnt_d = load_cnt_q + LW'(1);
        end
      end else begin
        mem_re_o = 1'b1;
        if (fend) begin
          load_cnt_d = '0;
          row_d      = '0;
          col_d      = '0;
        end else if (rend) begin
          col_d = '0;
          row_d = PW'(row_e + DW'(1));
        end else begin
          col_d = PW'(col_e + DW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      load_cnt_q <= load_cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
    end
  end

  assign info_o.row_end   = rend;
  assign info_o.frame_end = fend;
  assign info_o.ow        = cfg_i.ow;
  assign info_o.oh        = cfg_i.oh;

endmodule

/* sv/irqt_store.sv */
module irqt_store #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 8
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/image_rotate_quarter_turns_unit.sv */
// quarter-turn image rotator: load words write pixels of one frame in input
// row-major order into an on-chip frame store; fetch words return the frame
// turned by 0, 90, 180 or 270 degrees clockwise (left turns fold into the
// matching clockwise turn), one pixel per fetch in output row-major order,
// with row_end, frame_end and the turned dimensions (swapped for 90 and 270).
// one word is accepted every clock unless both stages are full and stalled,
// loads and fetches mixed freely; a fetch result passes the frame store's
// registered read port, then the output register. loads past the frame are
// dropped, and the fetch carrying frame_end rearms the loader. the store has
// no clearing pass: fetching a pixel never loaded returns undefined data.
// the user must change registers only while the block is idle; not enforced.
module image_rotate_quarter_turns_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int PIXEL_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [irqt_pkg::PADDR_W-1:0] paddr,
  input  logic [irqt_pkg::PDATA_W-1:0] pwdata,
  output logic [irqt_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [PIXEL_BITS-1:0]        pixel_in_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [PIXEL_BITS-1:0]        pixel_out_o,
  output logic                         row_end_o,
  output logic                         frame_end_o,
  output logic [irqt_pkg::DIM_W-1:0]   out_width_o,
  output logic [irqt_pkg::DIM_W-1:0]   out_height_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  irqt_pkg::cfg_t      cfg;
  irqt_pkg::out_info_t info;
  irqt_pkg::op_e       op;
  logic [AW-1:0]       mem_addr;
  logic                mem_we, mem_re;
  logic [PIXEL_BITS-1:0] rdata;
  logic                acc, fetch_acc;

  // stage 1 waits on the store read, stage 2 is the output register
  logic                s1_valid_q, s1_valid_d;
  irqt_pkg::out_info_t s1_info_q;
  logic                s1_adv;
  logic                out_valid_q, out_valid_d;
  logic [PIXEL_BITS-1:0] pixel_q;
  irqt_pkg::out_info_t out_info_q;

  assign pready = 1'b1;

  irqt_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign op        = irqt_pkg::op_e'(op_i);
  assign acc       = in_valid_i & in_ready_o;
  assign fetch_acc = acc & (op == irqt_pkg::OP_FETCH);

  // position counters, load counter and store address
  irqt_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .acc_i      (acc),
    .op_i       (op),
    .mem_addr_o (mem_addr),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .info_o     (info)
  );

  irqt_store #(
    .DEPTH  (DEPTH),
    .DATA_W (PIXEL_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .addr_i  (mem_addr),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .wdata_i (pixel_in_i),
    .rdata_o (rdata)
  );

  // the read data only changes on a fetch, which needs stage 1 free
  assign s1_adv      = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~s1_valid_q | s1_adv;
  assign s1_valid_d  = fetch_acc | (s1_valid_q & ~s1_adv);
  assign out_valid_d = s1_adv | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch_acc) begin
      s1_info_q <= info;
    end
    if (s1_adv) begin
      pixel_q    <= rdata;
      out_info_q <= s1_info_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_q;
  assign row_end_o    = out_info_q.row_end;
  assign frame_end_o  = out_info_q.frame_end;
  assign out_width_o  = out_info_q.ow;
  assign out_height_o = out_info_q.oh;

`ifndef SYNTH
  // the last pixel of a frame is always the last of its row
  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame_end without row_end");

  // both stages full and stalled: no new word may enter
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("word accepted into a full pipeline");

  // every accepted fetch occupies stage 1 next cycle
  a_fetch_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_acc |=> s1_valid_q)
    else $error("fetch lost before stage 1");

  // a load never produces a result word
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (op == irqt_pkg::OP_LOAD) && !s1_valid_q |=> !s1_valid_q)
    else $error("load produced a result");

  // rotated dimensions are never zero
  a_dims_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_width_o != '0) && (out_height_o != '0))
    else $error("zero output dimension");
`endif

endmodule
